// File: rtl/frt_pkg.sv
// shared constants, payload types and helper functions for the frame rotation block
`timescale 1ns / 1ps

package frt_pkg;

   localparam int COORD_BITS      = 32;
   localparam int ANGLE_BITS      = 16;
   localparam int ROTATION_STAGES = 16;

   // binary angle as a 32-bit fraction of a turn
   localparam int TURN_BITS  = 32;
   localparam int ATAN_COUNT = 32;
   localparam int CELL_COUNT = (ROTATION_STAGES < ATAN_COUNT) ? ROTATION_STAGES : ATAN_COUNT;
   localparam int STAGE_BITS = $clog2(ATAN_COUNT);

   localparam int GUARD_BITS = 60 - COORD_BITS;
   localparam int DIFF_BITS  = COORD_BITS + 2;
   localparam int VEC_BITS   = DIFF_BITS + GUARD_BITS + 2;
   localparam int SUM_BITS   = COORD_BITS + 6;
   localparam int MAG_BITS   = VEC_BITS - GUARD_BITS;

   // gain correction: 1/K in q30, magnitude split into two 32-bit halves for the multiply
   localparam int KINV_BITS = 30;
   localparam logic [KINV_BITS-1:0] KINV_Q30 = 30'd652032874;
   localparam int LO_BITS   = 32;
   localparam int HI_BITS   = VEC_BITS - LO_BITS;
   localparam int PLO_BITS  = LO_BITS + KINV_BITS;
   localparam int PHI_BITS  = HI_BITS + KINV_BITS;

   localparam logic OP_FORWARD = 1'b0;
   localparam logic OP_INVERSE = 1'b1;

   typedef struct packed {
      logic                          op;
      logic signed [COORD_BITS-1:0]  point_x;
      logic signed [COORD_BITS-1:0]  point_y;
      logic signed [COORD_BITS-1:0]  point_z;
      logic        [ANGLE_BITS-1:0]  point_heading;
      logic signed [COORD_BITS-1:0]  carrier_x;
      logic signed [COORD_BITS-1:0]  carrier_y;
      logic signed [COORD_BITS-1:0]  carrier_z;
      logic        [ANGLE_BITS-1:0]  carrier_heading;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  result_x;
      logic signed [COORD_BITS-1:0]  result_y;
      logic signed [COORD_BITS-1:0]  result_z;
      logic        [ANGLE_BITS-1:0]  result_heading;
   } rsp_type;

   // vector and residual angle moving down the rotation chain
   typedef struct packed {
      logic signed [VEC_BITS-1:0]   x;
      logic signed [VEC_BITS-1:0]   y;
      logic signed [TURN_BITS-1:0]  z;
   } vec_type;

   // values that ride along the chain untouched
   typedef struct packed {
      logic                          inverse;
      logic signed [COORD_BITS-1:0]  carrier_x;
      logic signed [COORD_BITS-1:0]  carrier_y;
      logic signed [COORD_BITS-1:0]  result_z;
      logic        [ANGLE_BITS-1:0]  result_heading;
   } side_type;

   function automatic logic [TURN_BITS-1:0] atan_step(input logic [STAGE_BITS-1:0] idx);
      logic [TURN_BITS-1:0] a;
      case (idx)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2FA;
         5'd15:   a = 32'h0000517D;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A30;
         5'd19:   a = 32'h00000518;
         5'd20:   a = 32'h0000028C;
         5'd21:   a = 32'h00000146;
         5'd22:   a = 32'h000000A3;
         5'd23:   a = 32'h00000051;
         5'd24:   a = 32'h00000029;
         5'd25:   a = 32'h00000014;
         5'd26:   a = 32'h0000000A;
         5'd27:   a = 32'h00000005;
         5'd28:   a = 32'h00000003;
         5'd29:   a = 32'h00000001;
         5'd30:   a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

   // clamp a wide signed value to the coordinate range
   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [SUM_BITS-1:0] v
   );
      logic [SUM_BITS-COORD_BITS:0] top;
      logic signed [COORD_BITS-1:0] r;
      top = v[SUM_BITS-1:COORD_BITS-1];
      if ((&top) || !(|top)) begin
         r = v[COORD_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         r = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// File: rtl/frt_prep.sv
// input stage: angle folding, carrier offset, z and heading arithmetic
`timescale 1ns / 1ps

module frt_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  frt_pkg::req_type    req_payload,
   output logic                out_valid,
   input  logic                out_ready,
   output frt_pkg::vec_type    out_vec,
   output frt_pkg::side_type   out_side
);

   logic                                    valid_ff, valid_in;
   frt_pkg::vec_type                        vec_ff, vec_in;
   frt_pkg::side_type                       side_ff, side_in;
   logic                                    enable;
   logic                                    inverse;
   logic [frt_pkg::TURN_BITS-1:0]           theta_fwd, theta_raw, theta;
   logic                                    fold;
   logic signed [frt_pkg::DIFF_BITS-1:0]    dx, dy, fx, fy;
   logic signed [frt_pkg::SUM_BITS-1:0]     z_sum;

   assign enable    = !valid_ff || out_ready;
   assign req_ready = enable;
   assign inverse   = req_payload.op == frt_pkg::OP_INVERSE;

   always_comb begin
      theta_fwd = {req_payload.carrier_heading,
                   {(frt_pkg::TURN_BITS-frt_pkg::ANGLE_BITS){1'b0}}};
      theta_raw = inverse ? (frt_pkg::TURN_BITS'(0) - theta_fwd) : theta_fwd;
      // second or third quadrant: turn the vector half a turn first
      fold  = theta_raw[frt_pkg::TURN_BITS-1] ^ theta_raw[frt_pkg::TURN_BITS-2];
      theta = fold ? {~theta_raw[frt_pkg::TURN_BITS-1], theta_raw[frt_pkg::TURN_BITS-2:0]}
                   : theta_raw;
      if (inverse) begin
         dx    = frt_pkg::DIFF_BITS'(req_payload.point_x) - frt_pkg::DIFF_BITS'(req_payload.carrier_x);
         dy    = frt_pkg::DIFF_BITS'(req_payload.point_y) - frt_pkg::DIFF_BITS'(req_payload.carrier_y);
         z_sum = frt_pkg::SUM_BITS'(req_payload.point_z) - frt_pkg::SUM_BITS'(req_payload.carrier_z);
      end else begin
         dx    = frt_pkg::DIFF_BITS'(req_payload.point_x);
         dy    = frt_pkg::DIFF_BITS'(req_payload.point_y);
         z_sum = frt_pkg::SUM_BITS'(req_payload.point_z) + frt_pkg::SUM_BITS'(req_payload.carrier_z);
      end
      fx = fold ? -dx : dx;
      fy = fold ? -dy : dy;

      vec_in.x = frt_pkg::VEC_BITS'(fx) <<< frt_pkg::GUARD_BITS;
      vec_in.y = frt_pkg::VEC_BITS'(fy) <<< frt_pkg::GUARD_BITS;
      vec_in.z = theta;

      side_in.inverse        = inverse;
      side_in.carrier_x      = req_payload.carrier_x;
      side_in.carrier_y      = req_payload.carrier_y;
      side_in.result_z       = frt_pkg::sat_coord(z_sum);
      side_in.result_heading = inverse ? (req_payload.point_heading - req_payload.carrier_heading)
                                       : (req_payload.point_heading + req_payload.carrier_heading);
      valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && req_valid) begin
         vec_ff  <= vec_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side_ff;

`ifndef ASSERT_OFF
   // folded angle must sit in the first or fourth quadrant
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_vec.z[frt_pkg::TURN_BITS-1] == out_vec.z[frt_pkg::TURN_BITS-2]))
      else $error("residual angle outside the convergence range");
`endif

endmodule

// File: rtl/frt_cell.sv
// one rotation cell: a single shift-add micro-rotation with its own register
`timescale 1ns / 1ps

module frt_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [frt_pkg::STAGE_BITS-1:0]    stage_idx,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  frt_pkg::vec_type                  in_vec,
   input  frt_pkg::side_type                 in_side,
   output logic                              out_valid,
   input  logic                              out_ready,
   output frt_pkg::vec_type                  out_vec,
   output frt_pkg::side_type                 out_side
);

   logic                                  valid_ff;
   frt_pkg::vec_type                      vec_ff, vec_in;
   frt_pkg::side_type                     side_ff;
   logic                                  enable;
   logic signed [frt_pkg::VEC_BITS-1:0]   x_cur, y_cur, x_sh, y_sh;
   logic [frt_pkg::TURN_BITS-1:0]         atan;

   assign enable   = !valid_ff || out_ready;
   assign in_ready = enable;

   always_comb begin
      x_cur = in_vec.x;
      y_cur = in_vec.y;
      x_sh  = x_cur >>> stage_idx;
      y_sh  = y_cur >>> stage_idx;
      atan  = frt_pkg::atan_step(stage_idx);
      // rotate toward zero residual
      if (!in_vec.z[frt_pkg::TURN_BITS-1]) begin
         vec_in.x = x_cur - y_sh;
         vec_in.y = y_cur + x_sh;
         vec_in.z = in_vec.z - atan;
      end else begin
         vec_in.x = x_cur + y_sh;
         vec_in.y = y_cur - x_sh;
         vec_in.z = in_vec.z + atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && in_valid) begin
         vec_ff  <= vec_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/frt_post.sv
// gain correction, rounding, carrier offset, saturation and the output register
`timescale 1ns / 1ps

module frt_post (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  frt_pkg::vec_type    in_vec,
   input  frt_pkg::side_type   in_side,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output frt_pkg::rsp_type    rsp_payload
);

   // stage 1: split magnitude products
   logic                                  mul_valid_ff;
   logic [1:0]                            neg_ff, neg_in;
   logic [1:0][frt_pkg::PHI_BITS-1:0]     phi_ff, phi_in;
   logic [1:0][frt_pkg::PLO_BITS-1:0]     plo_ff, plo_in;
   frt_pkg::side_type                     mul_side_ff;
   // stage 2: rounded magnitudes
   logic                                  rnd_valid_ff;
   logic [1:0]                            rnd_neg_ff;
   logic [1:0][frt_pkg::MAG_BITS-1:0]     mag_ff, mag_in;
   frt_pkg::side_type                     rnd_side_ff;
   // stage 3: output register
   logic                                  rsp_valid_ff;
   frt_pkg::rsp_type                      rsp_payload_ff, rsp_payload_in;

   logic                                  en_mul, en_rnd, en_out;
   logic [frt_pkg::VEC_BITS-1:0]          mag_v, p_sum, lo_round;
   logic signed [frt_pkg::VEC_BITS-1:0]   comp;
   logic [frt_pkg::HI_BITS-1:0]           hi_part;
   logic [frt_pkg::LO_BITS-1:0]           lo_part;
   logic signed [frt_pkg::SUM_BITS-1:0]   addend, mag_s;
   logic signed [frt_pkg::SUM_BITS-1:0]   total [2];

   assign en_out   = !rsp_valid_ff || rsp_ready;
   assign en_rnd   = !rnd_valid_ff || en_out;
   assign en_mul   = !mul_valid_ff || en_rnd;
   assign in_ready = en_mul;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         comp      = (k == 0) ? in_vec.x : in_vec.y;
         neg_in[k] = comp[frt_pkg::VEC_BITS-1];
         mag_v     = neg_in[k] ? frt_pkg::VEC_BITS'(-comp) : frt_pkg::VEC_BITS'(comp);
         hi_part   = mag_v[frt_pkg::VEC_BITS-1:frt_pkg::LO_BITS];
         lo_part   = mag_v[frt_pkg::LO_BITS-1:0];
         phi_in[k] = frt_pkg::PHI_BITS'(hi_part) * frt_pkg::PHI_BITS'(frt_pkg::KINV_Q30);
         plo_in[k] = frt_pkg::PLO_BITS'(lo_part) * frt_pkg::PLO_BITS'(frt_pkg::KINV_Q30);
      end
   end

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         lo_round  = (frt_pkg::VEC_BITS'(plo_ff[k])
                      + (frt_pkg::VEC_BITS'(1) << (frt_pkg::KINV_BITS-1))) >> frt_pkg::KINV_BITS;
         p_sum     = (frt_pkg::VEC_BITS'(phi_ff[k]) << (frt_pkg::LO_BITS-frt_pkg::KINV_BITS))
                     + lo_round;
         // round half away from zero on the magnitude, drop the guard bits
         mag_in[k] = frt_pkg::MAG_BITS'((p_sum + (frt_pkg::VEC_BITS'(1) << (frt_pkg::GUARD_BITS-1)))
                                        >> frt_pkg::GUARD_BITS);
      end
   end

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         if (rnd_side_ff.inverse) begin
            addend = '0;
         end else begin
            addend = (k == 0) ? frt_pkg::SUM_BITS'(rnd_side_ff.carrier_x)
                              : frt_pkg::SUM_BITS'(rnd_side_ff.carrier_y);
         end
         mag_s    = frt_pkg::SUM_BITS'(mag_ff[k]);
         total[k] = rnd_neg_ff[k] ? (addend - mag_s) : (addend + mag_s);
      end
      rsp_payload_in.result_x       = frt_pkg::sat_coord(total[0]);
      rsp_payload_in.result_y       = frt_pkg::sat_coord(total[1]);
      rsp_payload_in.result_z       = rnd_side_ff.result_z;
      rsp_payload_in.result_heading = rnd_side_ff.result_heading;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rnd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_mul) begin
            mul_valid_ff <= in_valid;
         end
         if (en_rnd) begin
            rnd_valid_ff <= mul_valid_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= rnd_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_mul && in_valid) begin
         neg_ff      <= neg_in;
         phi_ff      <= phi_in;
         plo_ff      <= plo_in;
         mul_side_ff <= in_side;
      end
      if (en_rnd && mul_valid_ff) begin
         rnd_neg_ff  <= neg_ff;
         mag_ff      <= mag_in;
         rnd_side_ff <= mul_side_ff;
      end
      if (en_out && rnd_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: rtl/frame_rotation_translation.sv
// top level: planar rotation plus translation between carrier and world frames
`timescale 1ns / 1ps

// Usage
// req channel: one point and carrier pose per transaction. op selects local to
//   world (rotate by carrier heading, then add carrier position) or world to
//   local (subtract carrier position, rotate by the negated heading).
// rsp channel: one transformed point per transaction, x/y/z saturated to the
//   coordinate range, heading wrapped modulo one turn. Results leave in order.
// Pipeline: one input stage, one cell per micro-rotation (sixteen rotation
//   cells), then the gain multiply, rounding and output register stages.
// Throughput: one transaction per cycle; every stage is a register with its
//   own valid bit, so the chain of rotation cells holds one point per cell.
// Stall: when rsp_ready is low the stages fill from the output backward and
//   req_ready drops only once every stage holds a point; empty slots still
//   accept new transactions.
// Reset: synchronous, clears all valid bits; the data registers are not reset.

module frame_rotation_translation (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  frt_pkg::req_type    req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output frt_pkg::rsp_type    rsp_payload
);

   logic [frt_pkg::CELL_COUNT:0]  chain_valid;
   logic [frt_pkg::CELL_COUNT:0]  chain_ready;
   frt_pkg::vec_type              chain_vec  [frt_pkg::CELL_COUNT+1];
   frt_pkg::side_type             chain_side [frt_pkg::CELL_COUNT+1];

   frt_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .out_valid   (chain_valid[0]),
      .out_ready   (chain_ready[0]),
      .out_vec     (chain_vec[0]),
      .out_side    (chain_side[0])
   );

   for (genvar i = 0; i < frt_pkg::CELL_COUNT; i++) begin : g_cell
      frt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (frt_pkg::STAGE_BITS'(i)),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_vec    (chain_vec[i]),
         .in_side   (chain_side[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_vec   (chain_vec[i+1]),
         .out_side  (chain_side[i+1])
      );
   end

   frt_post u_post (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (chain_valid[frt_pkg::CELL_COUNT]),
      .in_ready    (chain_ready[frt_pkg::CELL_COUNT]),
      .in_vec      (chain_vec[frt_pkg::CELL_COUNT]),
      .in_side     (chain_side[frt_pkg::CELL_COUNT]),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef ASSERT_OFF
   // a free or draining output stage must open the whole ready chain
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while the output side can move");

   // no result may appear right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // when the input stage holds a point and the first cell is empty, that cell must accept it
   assert property (@(posedge clock) disable iff (reset)
      (chain_valid[0] && !chain_valid[1]) |-> chain_ready[0])
      else $error("rotation chain blocked with an empty cell ahead");
`endif

endmodule
